// ===== hdl/ost_pkg.sv =====
// Package for the ordered set table.
// Holds the action and status codes, the controller state type and the
// command and status structs. It has no dependencies.
`default_nettype none

package ost_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_QUERY  = 3'd2,
        ACT_FIRST  = 3'd3,
        ACT_LAST   = 3'd4,
        ACT_CLEAR  = 3'd5
    } ost_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } ost_status_t;

    typedef enum logic [0:0] {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } ost_state_t;

    typedef struct packed {
        logic load;
        logic apply;
    } ost_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } ost_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ost_if.sv =====
// Handshake channels of the ordered set table: request and response.
// Depends on ost_pkg for the field widths.
`default_nettype none

interface ost_req_if
    import ost_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface ost_rsp_if
    import ost_pkg::*;
#(
    parameter int CNT_W = 7
)();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic                       present;
    logic signed [VALUE_W-1:0]  removed_value;
    logic [CNT_W-1:0]           element_count;

    modport source (output valid, output status, output present,
                    output removed_value, output element_count, input ready);
    modport sink   (input valid, input status, input present,
                    input removed_value, input element_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/ost_ctrl.sv =====
// Controller of the ordered set table: accepts a request, then applies it
// once the output register is free. Depends on ost_pkg.
`default_nettype none

module ost_ctrl
    import ost_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output ost_cmd_t       cmd,
    input  wire ost_stat_t stat
);

    ost_state_t state_reg;
    ost_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.apply  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // hold until the previous result has been taken
                if (!stat.out_blocked)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/ost_cells.sv =====
// Datapath of the ordered set table: the row of entry cells with their
// comparators, the element count and the output register. Depends on ost_pkg.
`default_nettype none

module ost_cells
    import ost_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CW    = 7
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ost_cmd_t                   cmd,
    output ost_stat_t                       stat,
    input  wire logic [ACTION_W-1:0]        action,
    input  wire logic signed [VALUE_W-1:0]  value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [STATUS_W-1:0]             status,
    output logic                            present,
    output logic signed [VALUE_W-1:0]       removed_value,
    output logic [CW-1:0]                   element_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0]   cell_reg [DEPTH];
    logic [VALUE_W-1:0]   cell_up  [DEPTH];
    logic [DEPTH-1:0]     match_reg;
    logic [DEPTH-1:0]     at_or_after;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [ACTION_W-1:0]  act_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 present_reg;
    logic [VALUE_W-1:0]   removed_reg;
    logic [CW-1:0]        ecount_reg;

    logic                 hit;
    logic                 empty;
    logic                 full;
    logic [IW-1:0]        last_idx;
    logic                 do_append;
    logic                 do_shift_hit;
    logic                 do_shift_all;
    ost_status_t          status_next;
    logic                 present_next;
    logic [VALUE_W-1:0]   removed_next;

    assign hit      = |match_reg;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign last_idx = IW'(count_reg - CW'(1));

    // compare all live cells against the incoming value
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            value_reg <= value;
            for (int i = 0; i < DEPTH; i++)
            begin
                match_reg[i] <= (CW'(i) < count_reg) && (cell_reg[i] == value);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign at_or_after[g] = |match_reg[g:0];
            if (g < DEPTH - 1)
            begin : g_up
                assign cell_up[g] = cell_reg[g+1];
            end
            else
            begin : g_top
                assign cell_up[g] = cell_reg[g];
            end

            always_ff @(posedge clk)
            begin
                if (do_append && (count_reg == CW'(g)))
                begin
                    cell_reg[g] <= value_reg;
                end
                else if (do_shift_all || (do_shift_hit && at_or_after[g]))
                begin
                    cell_reg[g] <= cell_up[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        status_next  = ST_DONE;
        present_next = 1'b0;
        removed_next = '0;
        count_next   = count_reg;
        do_append    = 1'b0;
        do_shift_hit = 1'b0;
        do_shift_all = 1'b0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (hit)
                begin
                    status_next  = ST_MISS;
                    present_next = 1'b1;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_append  = cmd.apply;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (hit)
                begin
                    present_next = 1'b1;
                    do_shift_hit = cmd.apply;
                    count_next   = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            ACT_QUERY:
            begin
                if (hit)
                begin
                    present_next = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            ACT_FIRST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    present_next = 1'b1;
                    removed_next = cell_reg[0];
                    do_shift_all = cmd.apply;
                    count_next   = count_reg - CW'(1);
                end
            end
            ACT_LAST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    present_next = 1'b1;
                    removed_next = cell_reg[last_idx];
                    count_next   = count_reg - CW'(1);
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            status_reg  <= status_next;
            present_reg <= present_next;
            removed_reg <= removed_next;
            ecount_reg  <= count_next;
        end
    end

    assign stat.out_blocked = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign present          = present_reg;
    assign removed_value    = removed_reg;
    assign element_count    = ecount_reg;

endmodule

`default_nettype wire

// ===== hdl/ordered_set_table.sv =====
// Ordered set table: a set of distinct signed 32-bit values kept in insertion
// order, with insert, remove, query, remove-first, remove-last and clear.
// A request is accepted in S_IDLE, where each of the DEPTH entry cells
// compares its value against the request in parallel into a match register;
// it is applied in S_APPLY, where the cells write or shift down by one and the
// response is loaded into the output register. The next request is taken only
// after the apply, so one request is in flight at a time; a response still held
// in the output register delays only the apply of the following request.
// No clearing pass is needed after reset.
// Depends on ost_pkg, ost_if, ost_ctrl and ost_cells.
`default_nettype none

module ordered_set_table
    import ost_pkg::*;
#(
    parameter int DEPTH = 64
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ost_req_if.sink    req,
    ost_rsp_if.source  rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    ost_cmd_t         cmd;
    ost_stat_t        stat;
    logic [CW-1:0]    count_out;

    ost_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ost_cells #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_cells (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (req.action),
        .value         (req.value),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .status        (rsp.status),
        .present       (rsp.present),
        .removed_value (rsp.removed_value),
        .element_count (count_out)
    );

    assign rsp.element_count = count_out;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.element_count <= CW'(DEPTH)))
        else $error("element count above capacity");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_EMPTY)) |->
            ((rsp.element_count == '0) && (rsp.removed_value == '0) && !rsp.present))
        else $error("empty status with nonzero payload");

    a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> !(rsp.valid && !rsp.ready))
        else $error("output register overwritten before transfer");

endmodule

`default_nettype wire
